FILE: sv/ethipx_pkg.sv
// ----------------------------------------------------------------------------
// ethipx_pkg
// Shared types, constants and status codes for the Ethernet/IPv4 extractor.
// ----------------------------------------------------------------------------
package ethipx_pkg;

  localparam int COUNT_W             = 17;
  localparam int MAX_FRAME_BYTES_DEF = 65536;

  localparam int ETH_HDR_BYTES = 14;
  localparam int IPV4_MIN_HDR  = 20;
  localparam int TCP_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES = 8;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // status codes
  localparam logic [2:0] ST_SHORT_ETH  = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4   = 3'd1;
  localparam logic [2:0] ST_SHORT_IPV4 = 3'd2;
  localparam logic [2:0] ST_BAD_IHL    = 3'd3;
  localparam logic [2:0] ST_ICMP       = 3'd4;
  localparam logic [2:0] ST_TCP        = 3'd5;
  localparam logic [2:0] ST_UDP        = 3'd6;
  localparam logic [2:0] ST_OTHER      = 3'd7;

  localparam int TDATA_W = 240;
  localparam int TUSER_W = 4;

  typedef logic [COUNT_W-1:0] count_t;

  // captured header fields as they stand after the current word
  typedef struct packed {
    logic [15:0] eth_type;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    count_t      len;
  } cap_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] eth_type;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic        ports_valid;
    count_t      frame_length;
  } res_t;

endpackage

FILE: sv/ethipx_capture.sv
// ----------------------------------------------------------------------------
// ethipx_capture
// Byte counter and header field capture registers.
// ----------------------------------------------------------------------------
module ethipx_capture
  import ethipx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output cap_t       cap_next
);

  localparam count_t MAX_CNT = COUNT_W'(MAX_FRAME_BYTES);

  count_t byte_count;
  cap_t   cap;

  logic   can_cap;
  count_t l4;
  count_t l4_off;
  logic   port_hit;

  assign can_cap = byte_count < MAX_CNT;
  assign l4      = COUNT_W'(ETH_HDR_BYTES) + COUNT_W'({cap.ihl, 2'b00});
  assign l4_off  = byte_count - l4;
  assign port_hit = can_cap && (byte_count > COUNT_W'(ETH_HDR_BYTES)) &&
                    (byte_count >= l4) && (byte_count < l4 + COUNT_W'(4));

  always_comb begin
    cap_next     = cap;
    cap_next.len = byte_count + COUNT_W'(can_cap);
    if (can_cap) begin
      if (byte_count < COUNT_W'(6)) begin
        cap_next.dst_mac = {cap.dst_mac[39:0], data_byte};
      end else if (byte_count < COUNT_W'(12)) begin
        cap_next.src_mac = {cap.src_mac[39:0], data_byte};
      end else if (byte_count < COUNT_W'(14)) begin
        cap_next.eth_type = {cap.eth_type[7:0], data_byte};
      end else if (byte_count == COUNT_W'(14)) begin
        cap_next.ihl = data_byte[3:0];
      end else if (byte_count == COUNT_W'(23)) begin
        cap_next.protocol = data_byte;
      end else if (byte_count >= COUNT_W'(26) && byte_count < COUNT_W'(30)) begin
        cap_next.src_ip = {cap.src_ip[23:0], data_byte};
      end else if (byte_count >= COUNT_W'(30) && byte_count < COUNT_W'(34)) begin
        cap_next.dst_ip = {cap.dst_ip[23:0], data_byte};
      end
    end
    // ports: first two L4 bytes are source, next two destination
    if (port_hit) begin
      if (l4_off[1]) begin
        cap_next.l4_dport = {cap.l4_dport[7:0], data_byte};
      end else begin
        cap_next.l4_sport = {cap.l4_sport[7:0], data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= last_byte ? '0 : cap_next.len;
    end
  end

  // payload captures need no reset: stale values never reach a result
  always_ff @(posedge clk) begin
    if (accept) begin
      cap <= cap_next;
    end
  end

endmodule

FILE: sv/ethipx_summary.sv
// ----------------------------------------------------------------------------
// ethipx_summary
// Classifies a finished frame and zeroes fields that do not apply.
// ----------------------------------------------------------------------------
module ethipx_summary
  import ethipx_pkg::*;
(
  input  cap_t cap,
  output res_t res
);

  logic [5:0] hdr;
  count_t     ip_end;
  logic       ports_ok;

  assign hdr    = {cap.ihl, 2'b00};
  assign ip_end = COUNT_W'(ETH_HDR_BYTES) + COUNT_W'(hdr);

  always_comb begin
    res              = '0;
    res.frame_length = cap.len;
    ports_ok         = 1'b0;
    if (cap.len < COUNT_W'(ETH_HDR_BYTES)) begin
      res.status = ST_SHORT_ETH;
    end else begin
      res.eth_type = cap.eth_type;
      res.src_mac  = cap.src_mac;
      res.dst_mac  = cap.dst_mac;
      if (cap.eth_type != ETYPE_IPV4) begin
        res.status = ST_NOT_IPV4;
      end else if (cap.len < COUNT_W'(ETH_HDR_BYTES + IPV4_MIN_HDR)) begin
        res.status = ST_SHORT_IPV4;
      end else if (hdr < 6'(IPV4_MIN_HDR) || cap.len < ip_end) begin
        res.status = ST_BAD_IHL;
      end else begin
        res.ip_protocol = cap.protocol;
        res.src_ip      = cap.src_ip;
        res.dst_ip      = cap.dst_ip;
        if (cap.protocol == PROTO_ICMP) begin
          res.status = ST_ICMP;
        end else if (cap.protocol == PROTO_TCP) begin
          res.status = ST_TCP;
          ports_ok   = cap.len >= ip_end + COUNT_W'(TCP_HDR_BYTES);
        end else if (cap.protocol == PROTO_UDP) begin
          res.status = ST_UDP;
          ports_ok   = cap.len >= ip_end + COUNT_W'(UDP_HDR_BYTES);
        end else begin
          res.status = ST_OTHER;
        end
        if (ports_ok) begin
          res.l4_sport    = cap.l4_sport;
          res.l4_dport    = cap.l4_dport;
          res.ports_valid = 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/ethernet_ipv4_header_extractor.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_extractor
// Parses Ethernet/IPv4/L4 headers from a byte stream, one summary per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte word per clock, frame after frame, no gaps, while s_axis_tready is high.
// A frame's summary is registered when its last byte is taken, into the output register or, if held, the skid entry.
// The two-entry output stage (register plus skid) lets bytes keep flowing while
// one summary waits; s_axis_tready drops only when both entries are full.
// Reset (rst, synchronous): clears the byte counter and both output entries.
module ethernet_ipv4_header_extractor
  import ethipx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input byte stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // data_byte
  input  logic               s_axis_tlast,  // last_byte
  // frame summary stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // eth_type[15:0], src_mac[63:16], dst_mac[111:64], ip_protocol[119:112],
  // src_ip[151:120], dst_ip[183:152], l4_sport[199:184], l4_dport[215:200],
  // frame_length[232:216], zero fill above
  output logic [TDATA_W-1:0] m_axis_tdata,
  // status[2:0], ports_valid[3]
  output logic [TUSER_W-1:0] m_axis_tuser
);

  logic accept;
  cap_t cap_next;
  res_t res;
  logic res_load;

  // output register and skid entry
  res_t out_res;
  logic out_valid;
  res_t skid_res;
  logic skid_valid;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign res_load      = accept && s_axis_tlast;

  // byte counter and field capture; cap_next already includes this byte
  ethipx_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(s_axis_tdata),
    .last_byte(s_axis_tlast),
    .cap_next (cap_next)
  );

  // status decision and field masking for the frame ending this cycle
  ethipx_summary u_summary (
    .cap(cap_next),
    .res(res)
  );

  // Output stage. A new summary goes straight to the output register when it
  // is free or draining; otherwise it parks in the skid entry, which blocks
  // further input until the output register takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || res_load;
      skid_valid <= 1'b0;
    end else if (res_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_load) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (TDATA_W - 233)'(0),
    out_res.frame_length,
    out_res.l4_dport,
    out_res.l4_sport,
    out_res.dst_ip,
    out_res.src_ip,
    out_res.ip_protocol,
    out_res.dst_mac,
    out_res.src_mac,
    out_res.eth_type
  };
  assign m_axis_tuser  = {out_res.ports_valid, out_res.status};

endmodule

FILE: sv/ethipx_checker.sv
// ----------------------------------------------------------------------------
// ethipx_checker
// Port-level checks for the header extractor, bound to the top level.
// ----------------------------------------------------------------------------
module ethipx_checker
  import ethipx_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               s_axis_tlast,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser
);

  // a pending summary is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("summary word dropped before handshake");

  // a summary appears only right after a last byte is taken
  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("summary without a frame end");

  // input stalls only while a summary is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
    else $error("input stalled with output free");

  // ports are only flagged for TCP or UDP, and are zero otherwise
  a_ports: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[3] &&
                       (m_axis_tuser[2:0] == ST_TCP || m_axis_tuser[2:0] == ST_UDP)) ||
                      (!m_axis_tuser[3] && m_axis_tdata[215:184] == 32'd0))
    else $error("ports flag inconsistent with status");

  // every frame has at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[232:216] != 17'd0)
    else $error("zero frame length");

endmodule

bind ethernet_ipv4_header_extractor ethipx_checker u_ethipx_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
